### design/cbf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbf_pkg : shared types and constants for the cubic Bezier flattener
// Holds the control tag carried alongside vertex data, the depth of the
// constant divider and the constant function that builds the Bernstein
// weight table.
// ----------------------------------------------------------------------------
package cbf_pkg;

	// Sample counter width, enough for the largest supported step count
	localparam int K_WIDTH = 6;

	// Register stages in the reciprocal divider
	localparam int DIV_LAT = 3;

	// Per-vertex control tag
	typedef struct packed {
		logic               valid;
		logic [K_WIDTH-1:0] k;
		logic               last;
	} tag_t;

	// Bernstein weight i at sample k, scaled by steps^3 (elaboration only)
	function automatic int bern_weight(input int steps, input int i, input int k);
		int r;
		int w;
		r = steps - k;
		unique case (i)
			0:       w = r * r * r;
			1:       w = 3 * r * r * k;
			2:       w = 3 * r * k * k;
			default: w = k * k * k;
		endcase
		return w;
	endfunction

endpackage : cbf_pkg
`default_nettype wire

### design/cubic_bezier_flattener_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cubic_bezier_flattener_core : uniform flattening of a cubic Bezier
// Samples the curve at t = k/STEPS and emits STEPS+1 polyline vertices.
// ----------------------------------------------------------------------------
// Usage:
//  - A request (four control points) is taken at a rising edge with start
//    high and busy low. busy is high while a curve is being sequenced and
//    drops in the cycle that issues its final vertex, so back-to-back curves
//    follow each other with no gap.
//  - Each curve yields STEPS+1 vertices on consecutive cycles, each shown
//    for one cycle with vertex_valid high; last_vertex marks k = STEPS.
//  - Throughput: one vertex per cycle, set by the sequencer; a new curve
//    can be taken while the last vertex of the previous one issues.
//  - Pipeline: after the request edge the sequencer issues sample 0, which
//    passes weight lookup, products, sum, rounding prep, the three-stage
//    reciprocal divide by 2*STEPS^3 in each axis, and sign restore.
//  - The receiver cannot stall; vertices are shown once and not held.
//  - Reset clears the sequencer and all strobes; curves in flight are lost.
// ----------------------------------------------------------------------------
module cubic_bezier_flattener_core import cbf_pkg::*; #(
	parameter int STEPS       = 10,
	parameter int COORD_WIDTH = 32
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           start,
	output logic                          busy,
	input  wire  signed [COORD_WIDTH-1:0] p0_x,
	input  wire  signed [COORD_WIDTH-1:0] p0_y,
	input  wire  signed [COORD_WIDTH-1:0] p1_x,
	input  wire  signed [COORD_WIDTH-1:0] p1_y,
	input  wire  signed [COORD_WIDTH-1:0] p2_x,
	input  wire  signed [COORD_WIDTH-1:0] p2_y,
	input  wire  signed [COORD_WIDTH-1:0] p3_x,
	input  wire  signed [COORD_WIDTH-1:0] p3_y,
	output logic                          vertex_valid,
	output logic signed [COORD_WIDTH-1:0] vertex_x,
	output logic signed [COORD_WIDTH-1:0] vertex_y,
	output logic [3:0]                    vertex_index,
	output logic                          last_vertex
);

	localparam int S3        = STEPS * STEPS * STEPS;
	localparam int W_WIDTH   = $clog2(S3 + 1);
	localparam int KI_WIDTH  = $clog2(STEPS + 1);
	// products, sum, rounding prep, divider stages, sign restore
	localparam int AXIS_LAT  = DIV_LAT + 4;

	logic signed [COORD_WIDTH-1:0] pts_in [8];
	logic signed [COORD_WIDTH-1:0] pts    [8];
	tag_t                          issue;

	logic [W_WIDTH-1:0]            wt_tab [STEPS+1][4];
	logic [W_WIDTH-1:0]            w_s1   [4];
	logic signed [COORD_WIDTH-1:0] px_s1  [4];
	logic signed [COORD_WIDTH-1:0] py_s1  [4];
	tag_t                          tag_s1;
	tag_t                          tag_d  [AXIS_LAT];

	assign pts_in[0] = p0_x;
	assign pts_in[1] = p0_y;
	assign pts_in[2] = p1_x;
	assign pts_in[3] = p1_y;
	assign pts_in[4] = p2_x;
	assign pts_in[5] = p2_y;
	assign pts_in[6] = p3_x;
	assign pts_in[7] = p3_y;

	cbf_seq #(
		.STEPS       (STEPS),
		.COORD_WIDTH (COORD_WIDTH)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.pts_in (pts_in),
		.pts    (pts),
		.issue  (issue)
	);

	// constant Bernstein weight table, scaled by STEPS^3
	for (genvar kk = 0; kk <= STEPS; kk++) begin : g_wk
		for (genvar i = 0; i < 4; i++) begin : g_wi
			assign wt_tab[kk][i] = W_WIDTH'(bern_weight(STEPS, i, kk));
		end
	end

	// stage 1: weight lookup and operand capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			w_s1[i]  <= wt_tab[issue.k[KI_WIDTH-1:0]][i];
			px_s1[i] <= pts[2*i];
			py_s1[i] <= pts[2*i+1];
		end
	end

	cbf_axis #(
		.COORD_WIDTH (COORD_WIDTH),
		.W_WIDTH     (W_WIDTH),
		.S3          (S3)
	) u_axis_x (
		.clk (clk),
		.p   (px_s1),
		.w   (w_s1),
		.res (vertex_x)
	);

	cbf_axis #(
		.COORD_WIDTH (COORD_WIDTH),
		.W_WIDTH     (W_WIDTH),
		.S3          (S3)
	) u_axis_y (
		.clk (clk),
		.p   (py_s1),
		.w   (w_s1),
		.res (vertex_y)
	);

	// tag line matched to the axis datapath latency
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < AXIS_LAT; j++) begin
				tag_d[j] <= '0;
			end
		end else begin
			tag_d[0] <= tag_s1;
			for (int j = 1; j < AXIS_LAT; j++) begin
				tag_d[j] <= tag_d[j-1];
			end
		end
	end

	assign vertex_valid = tag_d[AXIS_LAT-1].valid;
	assign vertex_index = tag_d[AXIS_LAT-1].k[3:0];
	assign last_vertex  = tag_d[AXIS_LAT-1].last;

	// assertions
	a_issue_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (issue.valid && (issue.k == '0)))
		else $error("request not followed by vertex zero");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(vertex_valid && last_vertex) |-> (vertex_index == 4'(STEPS)))
		else $error("final vertex carries wrong index");

	a_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(vertex_valid && !last_vertex) |=> vertex_valid)
		else $error("gap inside a curve");

	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		(vertex_valid && !last_vertex) |=>
		(vertex_index == 4'($past(vertex_index) + 4'd1)))
		else $error("vertex index did not advance by one");

endmodule : cubic_bezier_flattener_core
`default_nettype wire

### design/cbf_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbf_seq : request capture and vertex sequencer
// Latches the control points of a request and steps the sample number
// k from 0 to STEPS, one vertex per cycle.
// ----------------------------------------------------------------------------
module cbf_seq import cbf_pkg::*; #(
	parameter int STEPS       = 10,
	parameter int COORD_WIDTH = 32
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire  signed [COORD_WIDTH-1:0] pts_in [8],
	output logic signed [COORD_WIDTH-1:0] pts    [8],
	output tag_t                         issue
);

	localparam logic [K_WIDTH-1:0] K_LAST = K_WIDTH'(STEPS);

	logic signed [COORD_WIDTH-1:0] pts_q [8];
	logic [K_WIDTH-1:0]            k_q;
	logic                          active_q;
	logic                          accept;

	// a new request may land on the cycle that issues the final vertex
	assign busy   = active_q && (k_q != K_LAST);
	assign accept = start && !busy;

	// sample counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			k_q      <= '0;
		end else if (accept) begin
			active_q <= 1'b1;
			k_q      <= '0;
		end else if (active_q) begin
			if (k_q == K_LAST) begin
				active_q <= 1'b0;
			end else begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	// control points, held for the whole curve
	always_ff @(posedge clk) begin
		if (accept) begin
			pts_q <= pts_in;
		end
	end

	assign pts         = pts_q;
	assign issue.valid = active_q;
	assign issue.k     = k_q;
	assign issue.last  = (k_q == K_LAST);

endmodule : cbf_seq
`default_nettype wire

### design/cbf_cdiv.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbf_cdiv : division by a constant through reciprocal multiplication
// Floor quotient of any numerator below 2^NUM_WIDTH, taken as
// (num * RECIP) >> SHIFT. The wide product is split into four half-width
// partial products; three register stages in all.
// ----------------------------------------------------------------------------
module cbf_cdiv #(
	parameter int NUM_WIDTH   = 46,
	parameter int COORD_WIDTH = 32,
	parameter int DIVISOR     = 2000
) (
	input  wire                    clk,
	input  wire  [NUM_WIDTH-1:0]   num,
	output logic [COORD_WIDTH-1:0] quot
);

	// RECIP = ceil(2^SHIFT / DIVISOR) keeps the quotient exact over the range
	localparam int DIV_BITS = $clog2(DIVISOR);
	localparam int SHIFT    = NUM_WIDTH + DIV_BITS;
	localparam int MW       = NUM_WIDTH + 1;
	localparam int HW       = (MW + 1) / 2;
	localparam int PPW      = 2 * HW;
	localparam int TW       = 2 * PPW;

	localparam logic [SHIFT:0] POW_S      = (SHIFT+1)'(1) << SHIFT;
	localparam logic [SHIFT:0] RECIP_FULL =
		(POW_S + (SHIFT+1)'(DIVISOR - 1)) / (SHIFT+1)'(DIVISOR);
	localparam logic [PPW-1:0] RECIP      = PPW'(RECIP_FULL);
	localparam logic [HW-1:0]  RECIP_LO   = RECIP[HW-1:0];
	localparam logic [HW-1:0]  RECIP_HI   = RECIP[PPW-1:HW];

	logic [PPW-1:0]         num_w;
	logic [PPW-1:0]         pp_ll_s1;
	logic [PPW-1:0]         pp_lh_s1;
	logic [PPW-1:0]         pp_hl_s1;
	logic [PPW-1:0]         pp_hh_s1;
	logic [PPW:0]           cross_s2;
	logic [PPW-1:0]         pp_ll_s2;
	logic [PPW-1:0]         pp_hh_s2;
	logic [TW-1:0]          total;
	logic [COORD_WIDTH-1:0] quot_s3;

	assign num_w = PPW'(num);

	// half-width partial products
	always_ff @(posedge clk) begin
		pp_ll_s1 <= PPW'(num_w[HW-1:0])   * PPW'(RECIP_LO);
		pp_lh_s1 <= PPW'(num_w[HW-1:0])   * PPW'(RECIP_HI);
		pp_hl_s1 <= PPW'(num_w[PPW-1:HW]) * PPW'(RECIP_LO);
		pp_hh_s1 <= PPW'(num_w[PPW-1:HW]) * PPW'(RECIP_HI);
	end

	// cross terms folded together
	always_ff @(posedge clk) begin
		cross_s2 <= (PPW+1)'(pp_lh_s1) + (PPW+1)'(pp_hl_s1);
		pp_ll_s2 <= pp_ll_s1;
		pp_hh_s2 <= pp_hh_s1;
	end

	// outer terms do not overlap, so one add completes the product
	assign total = {pp_hh_s2, pp_ll_s2} + (TW'(cross_s2) << HW);

	always_ff @(posedge clk) begin
		quot_s3 <= total[SHIFT +: COORD_WIDTH];
	end

	assign quot = quot_s3;

endmodule : cbf_cdiv
`default_nettype wire

### design/cbf_axis.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbf_axis : one coordinate axis of the vertex datapath
// Weighted sum of the four control coordinates, then rounding division
// by steps^3 with ties away from zero.
// ----------------------------------------------------------------------------
module cbf_axis import cbf_pkg::*; #(
	parameter int COORD_WIDTH = 32,
	parameter int W_WIDTH     = 10,
	parameter int S3          = 1000
) (
	input  wire                           clk,
	input  wire  signed [COORD_WIDTH-1:0] p [4],
	input  wire         [W_WIDTH-1:0]     w [4],
	output logic signed [COORD_WIDTH-1:0] res
);

	localparam int PW = COORD_WIDTH + W_WIDTH + 1;
	localparam int SW = PW + 2;

	logic signed [PW-1:0]   prod_s2 [4];
	logic signed [SW-1:0]   sum_s3;
	logic [SW-1:0]          mag;
	logic [SW:0]            num;
	logic [SW:0]            num_s4;
	logic                   neg_s4;
	logic [DIV_LAT-1:0]     neg_d;
	logic [COORD_WIDTH-1:0] quot;
	logic signed [COORD_WIDTH-1:0] res_q;

	// products
	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			prod_s2[i] <= p[i] * $signed({1'b0, w[i]});
		end
	end

	// sum of the four terms
	always_ff @(posedge clk) begin
		sum_s3 <= SW'(prod_s2[0]) + SW'(prod_s2[1]) + SW'(prod_s2[2]) + SW'(prod_s2[3]);
	end

	// magnitude, then 2|n| + S3 for rounding against divisor 2*S3
	assign mag = sum_s3[SW-1] ? SW'(-sum_s3) : SW'(sum_s3);
	assign num = {mag, 1'b0} + (SW+1)'(S3);

	always_ff @(posedge clk) begin
		neg_s4 <= sum_s3[SW-1];
		num_s4 <= num;
	end

	cbf_cdiv #(
		.NUM_WIDTH   (SW + 1),
		.COORD_WIDTH (COORD_WIDTH),
		.DIVISOR     (2 * S3)
	) u_cdiv (
		.clk  (clk),
		.num  (num_s4),
		.quot (quot)
	);

	// sign rides alongside the divider
	always_ff @(posedge clk) begin
		neg_d <= {neg_d[DIV_LAT-2:0], neg_s4};
	end

	// reapply sign; the weighted average never leaves the coordinate range
	always_ff @(posedge clk) begin
		res_q <= neg_d[DIV_LAT-1] ? $signed(-quot) : $signed(quot);
	end

	assign res = res_q;

endmodule : cbf_axis
`default_nettype wire

### bench/cubic_bezier_flattener_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cubic_bezier_flattener_core_tb : self-checking bench for the Bezier flattener
// Sends curve requests through the start/busy handshake, predicts every
// polyline vertex with exact integer arithmetic and checks each strobed
// vertex against the oldest prediction still pending.
// ----------------------------------------------------------------------------
module cubic_bezier_flattener_core_tb;
	import cbf_pkg::*;

	localparam int     STEPS       = 10;
	localparam int     COORD_WIDTH = 32;
	localparam longint STEPS_CUBED = STEPS * STEPS * STEPS;
	localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef struct {
		coord_t p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y;
	} curve_t;

	typedef struct {
		coord_t     x;
		coord_t     y;
		logic [3:0] index;
		logic       last;
	} vertex_t;

	logic   clk;
	logic   arst_n;
	logic   start;
	logic   busy;
	coord_t p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y;
	logic   vertex_valid;
	coord_t vertex_x;
	coord_t vertex_y;
	logic [3:0] vertex_index;
	logic   last_vertex;

	vertex_t pending_vertices[$];
	int      fail_count = 0;

	cubic_bezier_flattener_core #(
		.STEPS       (STEPS),
		.COORD_WIDTH (COORD_WIDTH)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.p0_x         (p0_x),
		.p0_y         (p0_y),
		.p1_x         (p1_x),
		.p1_y         (p1_y),
		.p2_x         (p2_x),
		.p2_y         (p2_y),
		.p3_x         (p3_x),
		.p3_y         (p3_y),
		.vertex_valid (vertex_valid),
		.vertex_x     (vertex_x),
		.vertex_y     (vertex_y),
		.vertex_index (vertex_index),
		.last_vertex  (last_vertex)
	);

	// 20 ns clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// One axis of the curve at t = k/STEPS: exact Bernstein sum, rounded
	// half away from zero, clamped to the coordinate range
	function automatic coord_t bezier_axis_at(input coord_t c0, input coord_t c1,
			input coord_t c2, input coord_t c3, input int k);
		longint r;
		longint acc;
		longint mag;
		longint q;
		longint lim;
		bit     neg;
		r   = STEPS - k;
		acc = r * r * r * longint'(c0) + 3 * r * r * k * longint'(c1)
			+ 3 * r * k * k * longint'(c2) + longint'(k) * k * k * longint'(c3);
		neg = (acc < 0);
		mag = neg ? -acc : acc;
		q   = (2 * mag + STEPS_CUBED) / (2 * STEPS_CUBED);
		lim = neg ? (longint'(1) << (COORD_WIDTH - 1)) : (longint'(1) << (COORD_WIDTH - 1)) - 1;
		if (q > lim)
			q = lim;
		return coord_t'(neg ? -q : q);
	endfunction

	// Drive one request, wait for it to be taken, then queue its vertices
	task automatic send_curve(input curve_t c);
		vertex_t v;
		p0_x  <= c.p0_x;
		p0_y  <= c.p0_y;
		p1_x  <= c.p1_x;
		p1_y  <= c.p1_y;
		p2_x  <= c.p2_x;
		p2_y  <= c.p2_y;
		p3_x  <= c.p3_x;
		p3_y  <= c.p3_y;
		start <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		for (int k = 0; k <= STEPS; k++) begin
			v.x     = bezier_axis_at(c.p0_x, c.p1_x, c.p2_x, c.p3_x, k);
			v.y     = bezier_axis_at(c.p0_y, c.p1_y, c.p2_y, c.p3_y, k);
			v.index = 4'(k);
			v.last  = (k == STEPS);
			pending_vertices.push_back(v);
		end
	endtask

	task automatic pause_requests(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Hold requests off until every pending vertex has been seen
	task automatic wait_for_drain();
		start <= 1'b0;
		while (pending_vertices.size() != 0) @(posedge clk);
		repeat (COORD_WIDTH + 8) @(posedge clk);
	endtask

	function automatic curve_t make_curve(input coord_t c0x, input coord_t c0y,
			input coord_t c1x, input coord_t c1y, input coord_t c2x, input coord_t c2y,
			input coord_t c3x, input coord_t c3y);
		curve_t c;
		c.p0_x = c0x; c.p0_y = c0y; c.p1_x = c1x; c.p1_y = c1y;
		c.p2_x = c2x; c.p2_y = c2y; c.p3_x = c3x; c.p3_y = c3y;
		return c;
	endfunction

	// Coordinate drawn from one of several distributions
	function automatic coord_t random_coord(input int mode);
		case (mode)
			0: return coord_t'($urandom);
			1: return coord_t'($urandom_range(0, 8191)) - coord_t'(4096);
			default: begin
				case ($urandom_range(0, 5))
					0: return COORD_MAX;
					1: return COORD_MIN;
					2: return '0;
					3: return '1;
					4: return coord_t'(1);
					default: return coord_t'($urandom);
				endcase
			end
		endcase
	endfunction

	function automatic curve_t random_curve();
		int     sel;
		int     m[8];
		sel = $urandom_range(0, 9);
		for (int i = 0; i < 8; i++) begin
			if (sel < 6)
				m[i] = 0;
			else if (sel < 8)
				m[i] = 1;
			else if (sel == 8)
				m[i] = 2;
			else
				m[i] = $urandom_range(0, 2);
		end
		return make_curve(random_coord(m[0]), random_coord(m[1]), random_coord(m[2]),
			random_coord(m[3]), random_coord(m[4]), random_coord(m[5]),
			random_coord(m[6]), random_coord(m[7]));
	endfunction

	// Extreme control points, including full-scale swings across the range
	task automatic test_extremes();
		send_curve(make_curve('0, '0, '0, '0, '0, '0, '0, '0));
		pause_requests(3);
		send_curve(make_curve(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
			COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
		send_curve(make_curve(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
			COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
		send_curve(make_curve(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
			COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN));
		send_curve(make_curve(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
			COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX));
		pause_requests(14);
		send_curve(make_curve(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
			COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN));
		send_curve(make_curve('1, '1, '1, '1, '1, '1, '1, '1));
		send_curve(make_curve(coord_t'(1), '1, '0, COORD_MAX, COORD_MIN, '0,
			'1, coord_t'(1)));
	endtask

	// Samples landing exactly on a half LSB, both signs
	task automatic test_rounding_ties();
		send_curve(make_curve(coord_t'(4), -coord_t'(4), '0, '0, '0, '0, '0, '0));
		send_curve(make_curve('0, '0, '0, '0, '0, '0, -coord_t'(4), coord_t'(4)));
		pause_requests(1);
		send_curve(make_curve(coord_t'(12), -coord_t'(12), '0, '0, '0, '0,
			coord_t'(4), -coord_t'(4)));
		send_curve(make_curve('0, '0, coord_t'(4), -coord_t'(4), -coord_t'(4),
			coord_t'(4), '0, '0));
	endtask

	// Requests back to back with no gap between them
	task automatic test_back_to_back();
		repeat (4) send_curve(random_curve());
	endtask

	// Sender holds off until the block is completely drained
	task automatic test_drain_pause();
		send_curve(random_curve());
		wait_for_drain();
		send_curve(random_curve());
		send_curve(random_curve());
		wait_for_drain();
	endtask

	// Random curves with random request gaps
	task automatic test_random_with_gaps(input int count);
		for (int i = 0; i < count; i++) begin
			send_curve(random_curve());
			if ($urandom_range(0, 2) == 0)
				pause_requests($urandom_range(1, 14));
		end
	endtask

	// Random curves at full rate
	task automatic test_random_full_rate(input int count);
		for (int i = 0; i < count; i++)
			send_curve(random_curve());
	endtask

	// Vertex checker: every strobe must match the oldest pending vertex
	always @(posedge clk) begin
		vertex_t e;
		if (arst_n && vertex_valid !== 1'b0) begin
			if (pending_vertices.size() == 0) begin
				$display("%0t: unexpected vertex, expected none, got x=%0d y=%0d index=%0d",
					$time, vertex_x, vertex_y, vertex_index);
				fail_count++;
			end else begin
				e = pending_vertices.pop_front();
				if (vertex_valid !== 1'b1) begin
					$display("%0t: vertex_valid, expected 1, got %b", $time, vertex_valid);
					fail_count++;
				end
				if (vertex_x !== e.x) begin
					$display("%0t: vertex_x, expected %0d, got %0d", $time, e.x, vertex_x);
					fail_count++;
				end
				if (vertex_y !== e.y) begin
					$display("%0t: vertex_y, expected %0d, got %0d", $time, e.y, vertex_y);
					fail_count++;
				end
				if (vertex_index !== e.index) begin
					$display("%0t: vertex_index, expected %0d, got %0d", $time, e.index,
						vertex_index);
					fail_count++;
				end
				if (last_vertex !== e.last) begin
					$display("%0t: last_vertex, expected %b, got %b", $time, e.last,
						last_vertex);
					fail_count++;
				end
			end
		end
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	// Test sequence
	initial begin
		arst_n <= 1'b0;
		start  <= 1'b0;
		p0_x   <= '0;
		p0_y   <= '0;
		p1_x   <= '0;
		p1_y   <= '0;
		p2_x   <= '0;
		p2_y   <= '0;
		p3_x   <= '0;
		p3_y   <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_rounding_ties();
		test_back_to_back();
		test_drain_pause();
		test_random_with_gaps(140);
		test_random_full_rate(60);

		// drain and allow for any stray strobes
		start <= 1'b0;
		while (pending_vertices.size() != 0) @(posedge clk);
		repeat (COORD_WIDTH + 16) @(posedge clk);

		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
